// ===== src/cqs_pkg.sv =====
// cqs_pkg: shared types, constants and level/bin conversion helpers
// for the channel quality statistics map
// no dependencies
package cqs_pkg;

   // default sizes
   localparam int NUM_INDICES_DEF = 128;
   localparam int NUM_BINS_DEF    = 64;

   // fixed field widths
   localparam int DWELL_W = 16;
   localparam int DBM_W   = 8;
   localparam int DROP_W  = 32;
   localparam int CSR_W   = 16;

   // dwell count at which an entry stops taking notes
   localparam logic [DWELL_W-1:0] DWELL_MAX = 16'hFFFF;

   // register indexes
   localparam logic CSR_BIN_ZERO   = 1'b0;
   localparam logic CSR_MIN_DWELLS = 1'b1;

   // register reset values
   localparam logic signed [DBM_W-1:0] BIN_ZERO_RST   = -8'sd100;
   localparam logic [DWELL_W-1:0]      MIN_DWELLS_RST = 16'd4;

   // command codes
   typedef enum logic [1:0] {
      CMD_NOTE      = 2'd0,
      CMD_REPORT    = 2'd1,
      CMD_CLEAR     = 2'd2,
      CMD_CLEAR_ALL = 2'd3
   } cmd_type;

   // control sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_DIV
   } state_type;

   // dBm reading to bin, clamped to 0..top_bin
   function automatic logic [7:0] to_bin(input logic signed [DBM_W-1:0] dbm,
                                         input logic signed [DBM_W-1:0] zero,
                                         input logic [7:0] top_bin);
      logic signed [9:0] d;
      d = 10'(dbm) - 10'(zero);
      if (d < 10'sd0) begin
         return 8'd0;
      end else if (d > $signed({2'b00, top_bin})) begin
         return top_bin;
      end else begin
         return d[7:0];
      end
   endfunction

   // bin back to dBm, saturated to the signed 8-bit range
   function automatic logic signed [DBM_W-1:0] bin_to_dbm(input logic [7:0] bin,
                                                         input logic signed [DBM_W-1:0] zero);
      logic signed [9:0] v;
      v = $signed({2'b00, bin}) + 10'(zero);
      if (v > 10'sd127) begin
         return 8'sd127;
      end else if (v < -10'sd128) begin
         return -8'sd128;
      end else begin
         return v[7:0];
      end
   endfunction

endpackage

// ===== src/channel_quality_stats_map_unit.sv =====
// channel_quality_stats_map_unit: top level of the channel quality statistics map
// depends on cqs_pkg, cqs_ram (entry table) and cqs_div (mean division)
//
//   channel   ports                          transfer
//   request   start, busy, req_*             rising edge with start high, busy low
//   response  rsp_strobe, rsp_*              one cycle with rsp_strobe high
//   config    csr_we, csr_index, csr_wdata   rising edge with csr_we high
//
// note and clear commands, and reports that fail the gate, answer from the lookup
// state; other reports answer once the serial mean divider is done. the entry
// table is read at the request transfer and written back at the end of the
// following lookup cycle.
// reset clears per-entry valid bits at once, so no clearing pass is needed.
// the response side cannot stall; each result is shown for one cycle only.
module channel_quality_stats_map_unit #(
   parameter int NUM_INDICES = cqs_pkg::NUM_INDICES_DEF,
   parameter int NUM_BINS    = cqs_pkg::NUM_BINS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request
   input  logic                                  start,
   output logic                                  busy,
   input  logic [1:0]                            req_cmd,
   input  logic [7:0]                            req_rf_index,
   input  logic signed [cqs_pkg::DBM_W-1:0]      req_min_dbm,
   input  logic signed [cqs_pkg::DBM_W-1:0]      req_mean_dbm_in,
   input  logic [cqs_pkg::DWELL_W-1:0]           req_sample_count,
   // response
   output logic                                  rsp_strobe,
   output logic                                  rsp_ok,
   output logic [cqs_pkg::DWELL_W-1:0]           rsp_dwells,
   output logic signed [cqs_pkg::DBM_W-1:0]      rsp_floor_dbm,
   output logic signed [cqs_pkg::DBM_W-1:0]      rsp_busy_dbm,
   output logic signed [cqs_pkg::DBM_W-1:0]      rsp_mean_dbm_out,
   output logic [cqs_pkg::DROP_W-1:0]            rsp_dropped_count,
   // configuration
   input  logic                                  csr_we,
   input  logic                                  csr_index,
   input  logic [cqs_pkg::CSR_W-1:0]             csr_wdata
);

   import cqs_pkg::*;

   localparam int BIN_W = $clog2(NUM_BINS);
   localparam int IDX_W = (NUM_INDICES > 1) ? $clog2(NUM_INDICES) : 1;
   localparam int SUM_W = DWELL_W + BIN_W;
   localparam int ENT_W = SUM_W + DWELL_W + 2 * BIN_W;
   localparam logic [7:0] TOP_BIN = 8'(NUM_BINS - 1);

   // entry layout: {bin sum, dwells, min bin, max bin}
   localparam int MAX_LSB = 0;
   localparam int MIN_LSB = BIN_W;
   localparam int DW_LSB  = 2 * BIN_W;
   localparam int SUM_LSB = 2 * BIN_W + DWELL_W;

   // configuration registers
   logic signed [DBM_W-1:0] bin_zero_ff;
   logic [DWELL_W-1:0]      min_dwells_ff;

   // request holding registers
   state_type               state_ff, state_in;
   cmd_type                 cmd_ff;
   logic [7:0]              index_ff;
   logic signed [DBM_W-1:0] min_dbm_ff;
   logic signed [DBM_W-1:0] mean_dbm_ff;
   logic [DWELL_W-1:0]      samples_ff;

   // table state
   logic [NUM_INDICES-1:0]  valid_ff, valid_in;
   logic [DROP_W-1:0]       drop_ff, drop_in;

   // response registers
   logic                    strobe_ff, strobe_in;
   logic                    ok_ff, ok_in;
   logic [DWELL_W-1:0]      dwells_ff, dwells_in;
   logic signed [DBM_W-1:0] floor_ff, floor_in;
   logic signed [DBM_W-1:0] busy_lvl_ff, busy_lvl_in;
   logic signed [DBM_W-1:0] mean_ff, mean_in;

   // ram and divider hookup
   logic                    accept;
   logic [IDX_W-1:0]        rd_addr;
   logic [IDX_W-1:0]        look_addr;
   logic [ENT_W-1:0]        rd_data;
   logic                    wr_en;
   logic [ENT_W-1:0]        wr_data;
   logic                    div_start;
   logic                    div_done;
   logic [SUM_W-1:0]        div_quo;

   // lookup-cycle decode
   logic                    idx_ok;
   logic                    entry_live;
   logic [ENT_W-1:0]        entry;
   logic [SUM_W-1:0]        e_sum;
   logic [DWELL_W-1:0]      e_dwells;
   logic [BIN_W-1:0]        e_min;
   logic [BIN_W-1:0]        e_max;
   logic [BIN_W-1:0]        lo_bin;
   logic [BIN_W-1:0]        note_bin;
   logic [BIN_W-1:0]        new_min;
   logic [BIN_W-1:0]        new_max;
   logic                    first_dwell;
   logic                    report_ok;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign rd_addr   = req_rf_index[IDX_W-1:0];
   assign look_addr = index_ff[IDX_W-1:0];

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_zero_ff   <= BIN_ZERO_RST;
         min_dwells_ff <= MIN_DWELLS_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BIN_ZERO:   bin_zero_ff   <= csr_wdata[DBM_W-1:0];
            CSR_MIN_DWELLS: min_dwells_ff <= csr_wdata[DWELL_W-1:0];
            default:        ;
         endcase
      end
   end

   // capture the request on transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff      <= cmd_type'(req_cmd);
         index_ff    <= req_rf_index;
         min_dbm_ff  <= req_min_dbm;
         mean_dbm_ff <= req_mean_dbm_in;
         samples_ff  <= req_sample_count;
      end
   end

   // entry table
   cqs_ram #(
      .WIDTH(ENT_W),
      .DEPTH(NUM_INDICES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (look_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // mean divider
   cqs_div #(
      .DIVIDEND_W(SUM_W),
      .DIVISOR_W (DWELL_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (e_sum),
      .divisor  (e_dwells),
      .done     (div_done),
      .quotient (div_quo)
   );

   // entry as read, zero where never written since the last clear
   assign idx_ok      = {1'b0, index_ff} < 9'(NUM_INDICES);
   assign entry_live  = idx_ok && valid_ff[look_addr];
   assign entry       = entry_live ? rd_data : '0;
   assign e_sum       = entry[SUM_LSB +: SUM_W];
   assign e_dwells    = entry[DW_LSB +: DWELL_W];
   assign e_min       = entry[MIN_LSB +: BIN_W];
   assign e_max       = entry[MAX_LSB +: BIN_W];

   // note update
   assign lo_bin      = BIN_W'(to_bin(min_dbm_ff, bin_zero_ff, TOP_BIN));
   assign note_bin    = BIN_W'(to_bin(mean_dbm_ff, bin_zero_ff, TOP_BIN));
   assign first_dwell = (e_dwells == '0);
   assign new_min     = (first_dwell || lo_bin < e_min) ? lo_bin : e_min;
   assign new_max     = (first_dwell || note_bin > e_max) ? note_bin : e_max;
   assign wr_data     = {e_sum + SUM_W'(note_bin), e_dwells + DWELL_W'(1), new_min, new_max};

   // report gate: a zero threshold acts as one
   assign report_ok   = idx_ok && (e_dwells >= min_dwells_ff) && !first_dwell;

   // sequencer and response build
   always_comb begin
      state_in    = state_ff;
      valid_in    = valid_ff;
      drop_in     = drop_ff;
      wr_en       = 1'b0;
      div_start   = 1'b0;
      strobe_in   = 1'b0;
      ok_in       = ok_ff;
      dwells_in   = dwells_ff;
      floor_in    = floor_ff;
      busy_lvl_in = busy_lvl_ff;
      mean_in     = mean_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in    = ST_IDLE;
            strobe_in   = 1'b1;
            ok_in       = 1'b0;
            dwells_in   = '0;
            floor_in    = '0;
            busy_lvl_in = '0;
            mean_in     = '0;
            case (cmd_ff)
               CMD_NOTE: begin
                  if (!idx_ok || samples_ff == '0) begin
                     drop_in = drop_ff + DROP_W'(1);
                  end else if (e_dwells != DWELL_MAX) begin
                     wr_en               = 1'b1;
                     valid_in[look_addr] = 1'b1;
                     ok_in               = 1'b1;
                  end
               end
               CMD_REPORT: begin
                  if (report_ok) begin
                     // floor and busy now, mean after the division
                     state_in    = ST_DIV;
                     strobe_in   = 1'b0;
                     div_start   = 1'b1;
                     ok_in       = 1'b1;
                     dwells_in   = e_dwells;
                     floor_in    = bin_to_dbm(8'(e_min), bin_zero_ff);
                     busy_lvl_in = bin_to_dbm(8'(e_max), bin_zero_ff);
                  end
               end
               CMD_CLEAR: begin
                  if (idx_ok) begin
                     valid_in[look_addr] = 1'b0;
                     ok_in               = 1'b1;
                  end
               end
               CMD_CLEAR_ALL: begin
                  valid_in = '0;
                  drop_in  = '0;
                  ok_in    = 1'b1;
               end
               default: ;
            endcase
         end
         ST_DIV: begin
            if (div_done) begin
               state_in  = ST_IDLE;
               strobe_in = 1'b1;
               mean_in   = bin_to_dbm(8'(div_quo[BIN_W-1:0]), bin_zero_ff);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         valid_ff  <= '0;
         drop_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         drop_ff   <= drop_in;
         strobe_ff <= strobe_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      ok_ff       <= ok_in;
      dwells_ff   <= dwells_in;
      floor_ff    <= floor_in;
      busy_lvl_ff <= busy_lvl_in;
      mean_ff     <= mean_in;
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_ok            = ok_ff;
   assign rsp_dwells        = dwells_ff;
   assign rsp_floor_dbm     = floor_ff;
   assign rsp_busy_dbm      = busy_lvl_ff;
   assign rsp_mean_dbm_out  = mean_ff;
   assign rsp_dropped_count = drop_ff;

endmodule

// ===== src/cqs_ram.sv =====
// cqs_ram: generic single-port-write, registered-read RAM
// no dependencies
module cqs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/cqs_div.sv =====
// cqs_div: restoring divider, one quotient bit per cycle
// no dependencies
module cqs_div #(
   parameter int DIVIDEND_W = 22,
   parameter int DIVISOR_W  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  div_ff, div_in;
   logic [DIVISOR_W:0]    trial;

   // one shift-and-subtract step
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      trial   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      if (start) begin
         run_in = 1'b1;
         cnt_in = CNT_W'(DIVIDEND_W);
         rem_in = '0;
         quo_in = dividend;
         div_in = divisor;
      end else if (run_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = DIVISOR_W'(trial - {1'b0, div_ff});
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== test/tb_top.sv =====
// tb_top: self-checking testbench for channel_quality_stats_map_unit
// depends on cqs_pkg for the command codes, register indexes and widths,
// and on the channel_quality_stats_map_unit RTL
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import cqs_pkg::*;

   localparam int NUM_IDX      = NUM_INDICES_DEF;
   localparam int BIN_TOP      = NUM_BINS_DEF - 1;
   localparam int RUN_LIMIT    = 2_000_000;
   localparam int TAIL_CYCLES  = 40;
   localparam int RANDOM_ITEMS = 370;
   localparam int FILL_NOTES   = 200;

   typedef struct {
      cmd_type                 cmd;
      logic [7:0]              chan;
      logic signed [DBM_W-1:0] min_dbm;
      logic signed [DBM_W-1:0] mean_lvl;
      logic [DWELL_W-1:0]      sample_count;
   } dwell_cmd_type;

   typedef struct {
      logic                    ok;
      logic [DWELL_W-1:0]      dwells;
      logic signed [DBM_W-1:0] floor_lvl;
      logic signed [DBM_W-1:0] busy_lvl;
      logic signed [DBM_W-1:0] avg_lvl;
      logic [DROP_W-1:0]       dropped;
   } stat_reply_type;

   typedef struct {
      logic [31:0]        bin_total;
      logic [DWELL_W-1:0] dwells;
      logic [7:0]         min_bin;
      logic [7:0]         max_bin;
   } chan_stat_type;

   // block ports
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [1:0]              req_cmd = CMD_NOTE;
   logic [7:0]              req_rf_index = '0;
   logic signed [DBM_W-1:0] req_min_dbm = '0;
   logic signed [DBM_W-1:0] req_mean_dbm_in = '0;
   logic [DWELL_W-1:0]      req_sample_count = '0;
   logic                    rsp_strobe;
   logic                    rsp_ok;
   logic [DWELL_W-1:0]      rsp_dwells;
   logic signed [DBM_W-1:0] rsp_floor_dbm;
   logic signed [DBM_W-1:0] rsp_busy_dbm;
   logic signed [DBM_W-1:0] rsp_mean_dbm_out;
   logic [DROP_W-1:0]       rsp_dropped_count;
   logic                    csr_we = 1'b0;
   logic                    csr_index = CSR_BIN_ZERO;
   logic [CSR_W-1:0]        csr_wdata = '0;

   // shadow of the statistics map and its registers
   chan_stat_type           chan_map [NUM_IDX];
   logic [DROP_W-1:0]       drop_total;
   logic signed [DBM_W-1:0] zero_level;
   logic [DWELL_W-1:0]      dwell_need;
   stat_reply_type          replies_due [$];

   int errors      = 0;
   int cycle_count = 0;
   int gap_pct     = 15;

   channel_quality_stats_map_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_rf_index      (req_rf_index),
      .req_min_dbm       (req_min_dbm),
      .req_mean_dbm_in   (req_mean_dbm_in),
      .req_sample_count  (req_sample_count),
      .rsp_strobe        (rsp_strobe),
      .rsp_ok            (rsp_ok),
      .rsp_dwells        (rsp_dwells),
      .rsp_floor_dbm     (rsp_floor_dbm),
      .rsp_busy_dbm      (rsp_busy_dbm),
      .rsp_mean_dbm_out  (rsp_mean_dbm_out),
      .rsp_dropped_count (rsp_dropped_count),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // dBm reading to 1 dB bin, clamped to the bin range
   function automatic logic [7:0] dbm_to_bin(input logic signed [DBM_W-1:0] dbm);
      int d;
      d = int'(dbm) - int'(zero_level);
      if (d < 0) return 8'd0;
      if (d > BIN_TOP) return 8'(BIN_TOP);
      return 8'(d);
   endfunction

   // bin back to dBm, saturated to the signed byte range
   function automatic logic signed [DBM_W-1:0] bin_to_level(input int bin);
      int v;
      v = bin + int'(zero_level);
      if (v > 127) v = 127;
      if (v < -128) v = -128;
      return 8'(v);
   endfunction

   function automatic dwell_cmd_type make_cmd(input cmd_type cmd, input int idx, input int mn,
                                              input int me, input int sc);
      dwell_cmd_type c;
      c.cmd          = cmd;
      c.chan         = 8'(idx);
      c.min_dbm      = 8'(mn);
      c.mean_lvl     = 8'(me);
      c.sample_count = 16'(sc);
      return c;
   endfunction

   // fold one command into the shadow map and queue the reply it must give
   task automatic predict_reply(input dwell_cmd_type c);
      stat_reply_type r;
      logic           in_range;
      logic [7:0]     lo_bin;
      logic [7:0]     avg_bin;
      int             need;
      r = '{default: '0};
      in_range = c.chan < NUM_IDX;
      case (c.cmd)
         CMD_NOTE: begin
            if (!in_range || c.sample_count == 0) begin
               drop_total = drop_total + 1'b1;
            end else if (chan_map[c.chan].dwells != DWELL_MAX) begin
               lo_bin  = dbm_to_bin(c.min_dbm);
               avg_bin = dbm_to_bin(c.mean_lvl);
               // first dwell stores both bins without comparing
               if (chan_map[c.chan].dwells == 0 || lo_bin < chan_map[c.chan].min_bin)
                  chan_map[c.chan].min_bin = lo_bin;
               if (chan_map[c.chan].dwells == 0 || avg_bin > chan_map[c.chan].max_bin)
                  chan_map[c.chan].max_bin = avg_bin;
               chan_map[c.chan].bin_total = chan_map[c.chan].bin_total + avg_bin;
               chan_map[c.chan].dwells    = chan_map[c.chan].dwells + 1'b1;
               r.ok = 1'b1;
            end
         end
         CMD_REPORT: begin
            // a zero threshold acts as one
            need = (dwell_need == 0) ? 1 : int'(dwell_need);
            if (in_range && int'(chan_map[c.chan].dwells) >= need) begin
               r.ok        = 1'b1;
               r.dwells    = chan_map[c.chan].dwells;
               r.floor_lvl = bin_to_level(int'(chan_map[c.chan].min_bin));
               r.busy_lvl  = bin_to_level(int'(chan_map[c.chan].max_bin));
               r.avg_lvl   = bin_to_level(int'(chan_map[c.chan].bin_total /
                                               chan_map[c.chan].dwells));
            end
         end
         CMD_CLEAR: begin
            if (in_range) begin
               chan_map[c.chan] = '{default: '0};
               r.ok = 1'b1;
            end
         end
         CMD_CLEAR_ALL: begin
            foreach (chan_map[i]) chan_map[i] = '{default: '0};
            drop_total = '0;
            r.ok = 1'b1;
         end
         default: ;
      endcase
      r.dropped = drop_total;
      replies_due.push_back(r);
   endtask

   // one request transfer, with random sender gaps in front of it
   task automatic send_cmd(input dwell_cmd_type c);
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start            = 1'b1;
      req_cmd          = c.cmd;
      req_rf_index     = c.chan;
      req_min_dbm      = c.min_dbm;
      req_mean_dbm_in  = c.mean_lvl;
      req_sample_count = c.sample_count;
      do @(posedge clock); while (busy);
      predict_reply(c);
   endtask

   // drop start and wait for every outstanding reply
   task automatic wait_idle();
      @(negedge clock);
      start = 1'b0;
      while (replies_due.size() != 0 || busy) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_BIN_ZERO) zero_level = value[DBM_W-1:0];
      else dwell_need = value;
   endtask

   // both registers, upper bits of the level write are don't-care
   task automatic set_config(input int zero, input int need);
      wait_idle();
      write_reg(CSR_BIN_ZERO, {8'($urandom), 8'(zero)});
      write_reg(CSR_MIN_DWELLS, 16'(need));
   endtask

   // levels mostly inside the bin window, sometimes anywhere
   function automatic logic signed [DBM_W-1:0] random_level();
      int lvl;
      if ($urandom_range(9) < 7) begin
         lvl = int'(zero_level) + int'($urandom_range(BIN_TOP + 8)) - 4;
         if (lvl > 127) lvl = 127;
         if (lvl < -128) lvl = -128;
         return 8'(lvl);
      end
      return 8'($urandom);
   endfunction

   // mostly notes and reports on a few hot channels, plus noise
   function automatic dwell_cmd_type random_cmd();
      dwell_cmd_type c;
      int            pick;
      pick = $urandom_range(99);
      if (pick < 62) c.cmd = CMD_NOTE;
      else if (pick < 95) c.cmd = CMD_REPORT;
      else if (pick < 99) c.cmd = CMD_CLEAR;
      else c.cmd = CMD_CLEAR_ALL;
      pick = $urandom_range(99);
      if (pick < 70)
         c.chan = 8'($urandom_range(3) + ($urandom_range(1) ? NUM_IDX - 4 : 0));
      else if (pick < 90)
         c.chan = 8'($urandom_range(NUM_IDX - 1));
      else
         c.chan = 8'($urandom_range(255, NUM_IDX));
      c.min_dbm  = random_level();
      c.mean_lvl = random_level();
      pick = $urandom_range(99);
      if (pick < 6) c.sample_count = '0;
      else if (pick < 10) c.sample_count = DWELL_MAX;
      else c.sample_count = 16'($urandom_range(65535, 1));
      return c;
   endfunction

   // field extremes, drops, readiness, clears, all at reset register values
   task automatic test_directed();
      send_cmd(make_cmd(CMD_REPORT, 0, 0, 0, 0));
      send_cmd(make_cmd(CMD_NOTE, 0, -128, 127, 1));
      send_cmd(make_cmd(CMD_NOTE, 0, 127, -128, 65535));
      send_cmd(make_cmd(CMD_NOTE, 0, -90, -70, 100));
      send_cmd(make_cmd(CMD_REPORT, 0, 0, 0, 0));
      send_cmd(make_cmd(CMD_NOTE, 0, -95, -80, 0));
      send_cmd(make_cmd(CMD_NOTE, 128, -95, -80, 9));
      send_cmd(make_cmd(CMD_NOTE, 255, 127, 127, 65535));
      send_cmd(make_cmd(CMD_NOTE, 0, -99, -100, 7));
      send_cmd(make_cmd(CMD_REPORT, 0, 0, 0, 0));
      send_cmd(make_cmd(CMD_NOTE, 127, -50, -60, 3));
      send_cmd(make_cmd(CMD_REPORT, 128, 0, 0, 0));
      send_cmd(make_cmd(CMD_REPORT, 255, 0, 0, 0));
      send_cmd(make_cmd(CMD_CLEAR, 255, 0, 0, 0));
      send_cmd(make_cmd(CMD_CLEAR, 128, 0, 0, 0));
      send_cmd(make_cmd(CMD_CLEAR, 0, 0, 0, 0));
      send_cmd(make_cmd(CMD_REPORT, 0, 0, 0, 0));
      send_cmd(make_cmd(CMD_REPORT, 127, 0, 0, 0));
      send_cmd(make_cmd(CMD_CLEAR_ALL, 200, -1, -1, 65535));
      send_cmd(make_cmd(CMD_NOTE, 127, -100, -37, 1));
      send_cmd(make_cmd(CMD_CLEAR_ALL, 3, 0, 0, 0));
      send_cmd(make_cmd(CMD_REPORT, 127, 0, 0, 0));
   endtask

   // levels written at one bin zero and read back at another saturate
   task automatic test_level_overflow();
      set_config(-128, 1);
      send_cmd(make_cmd(CMD_NOTE, 9, 127, 127, 1));
      send_cmd(make_cmd(CMD_NOTE, 10, -128, -128, 2));
      send_cmd(make_cmd(CMD_NOTE, 11, 0, -30, 3));
      send_cmd(make_cmd(CMD_REPORT, 9, 0, 0, 0));
      send_cmd(make_cmd(CMD_REPORT, 10, 0, 0, 0));
      set_config(127, 1);
      send_cmd(make_cmd(CMD_REPORT, 9, 0, 0, 0));
      send_cmd(make_cmd(CMD_REPORT, 10, 0, 0, 0));
      send_cmd(make_cmd(CMD_REPORT, 11, 0, 0, 0));
      send_cmd(make_cmd(CMD_NOTE, 12, -128, 127, 4));
      send_cmd(make_cmd(CMD_REPORT, 12, 0, 0, 0));
   endtask

   // zero threshold never reports an empty entry
   task automatic test_zero_min_dwells();
      set_config(-100, 0);
      send_cmd(make_cmd(CMD_CLEAR, 20, 0, 0, 0));
      send_cmd(make_cmd(CMD_REPORT, 20, 0, 0, 0));
      send_cmd(make_cmd(CMD_NOTE, 20, -110, -20, 5));
      send_cmd(make_cmd(CMD_REPORT, 20, 0, 0, 0));
   endtask

   // fill one entry up to a high report threshold, mostly with the top mean bin
   task automatic test_threshold_fill();
      int n;
      set_config(-100, FILL_NOTES);
      gap_pct = 0;
      send_cmd(make_cmd(CMD_CLEAR, 5, 0, 0, 0));
      for (n = 0; n < FILL_NOTES - 1; n++) begin
         send_cmd(make_cmd(CMD_NOTE, 5, int'($urandom),
                           ($urandom_range(15) == 0) ? int'($urandom) : 127,
                           int'($urandom_range(65535, 1))));
      end
      send_cmd(make_cmd(CMD_REPORT, 5, 0, 0, 0));
      send_cmd(make_cmd(CMD_NOTE, 5, -100, 127, 1));
      send_cmd(make_cmd(CMD_REPORT, 5, 0, 0, 0));
      send_cmd(make_cmd(CMD_NOTE, 5, -128, 127, 0));
      send_cmd(make_cmd(CMD_REPORT, 5, 0, 0, 0));
   endtask

   task automatic test_random(input int pct, input int zero, input int need);
      set_config(zero, need);
      gap_pct = pct;
      repeat (RANDOM_ITEMS) send_cmd(random_cmd());
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   // compare each result transfer with the oldest expected reply
   always @(posedge clock) begin
      stat_reply_type want;
      if (!reset && rsp_strobe) begin
         if (replies_due.size() == 0) begin
            report_mismatch("unexpected reply", 1, 0);
         end else begin
            want = replies_due.pop_front();
            if (rsp_ok !== want.ok) report_mismatch("ok", rsp_ok, want.ok);
            if (rsp_dwells !== want.dwells) report_mismatch("dwells", rsp_dwells, want.dwells);
            if (rsp_floor_dbm !== want.floor_lvl)
               report_mismatch("floor level", rsp_floor_dbm, want.floor_lvl);
            if (rsp_busy_dbm !== want.busy_lvl)
               report_mismatch("busy level", rsp_busy_dbm, want.busy_lvl);
            if (rsp_mean_dbm_out !== want.avg_lvl)
               report_mismatch("average level", rsp_mean_dbm_out, want.avg_lvl);
            if (rsp_dropped_count !== want.dropped)
               report_mismatch("drop count", rsp_dropped_count, want.dropped);
         end
      end
   end

   // run limit
   initial begin
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   // test sequence
   initial begin
      foreach (chan_map[i]) chan_map[i] = '{default: '0};
      drop_total = '0;
      zero_level = BIN_ZERO_RST;
      dwell_need = MIN_DWELLS_RST;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_level_overflow();
      test_zero_min_dwells();
      test_threshold_fill();
      test_random(15, -100, 4);
      test_random(45, -128, 1);
      test_random(0, -40, 3);

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (replies_due.size() != 0) report_mismatch("missing replies", 0, replies_due.size());
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
